// ===== rtl/rmf_pkg.sv =====
`timescale 1ns / 1ps

package rmf_pkg;

    localparam int RADIUS    = 1;
    localparam int MAX_WIDTH = 2048;

    localparam int NLINES = 2 * RADIUS;
    localparam int SPAN   = 2 * RADIUS + 1;
    localparam int NWIN   = SPAN * SPAN;
    localparam int HALF   = NWIN / 2;

    localparam int CH_W   = 8;
    localparam int PIX_W  = 3 * CH_W;
    localparam int CFG_W  = 12;
    localparam int ROW_W  = 12;
    localparam int COL_W  = $clog2(MAX_WIDTH);
    localparam int WEXT_W = (COL_W + 1 > CFG_W) ? COL_W + 1 : CFG_W;
    localparam int LINE_W = NLINES * PIX_W;

    localparam int CFG_IDX_W = 1;
    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH  = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = 1'd1;

    localparam logic [CFG_W-1:0] IMAGE_WIDTH_RST  = 12'd640;
    localparam logic [CFG_W-1:0] IMAGE_HEIGHT_RST = 12'd480;

    typedef struct packed {
        logic [CH_W-1:0] red_in;
        logic [CH_W-1:0] green_in;
        logic [CH_W-1:0] blue_in;
    } pix_in_t;

    typedef struct packed {
        logic [CH_W-1:0] red_med;
        logic [CH_W-1:0] green_med;
        logic [CH_W-1:0] blue_med;
        logic            frame_last;
    } pix_out_t;

    typedef struct packed {
        logic [CFG_W-1:0] width;
        logic [CFG_W-1:0] height;
    } dims_t;

    typedef struct packed {
        logic valid;
        logic last;
    } win_ctl_t;

    typedef pix_in_t [NLINES-1:0] line_vec_t;
    typedef pix_in_t [SPAN-1:0][SPAN-1:0] win_t;
    typedef logic [NWIN-1:0][CH_W-1:0] chan_arr_t;

    // odd-even transposition passes first..last-1
    function automatic chan_arr_t oets(input chan_arr_t a, input int first, input int last);
        chan_arr_t       v;
        logic [CH_W-1:0] t;
        v = a;
        t = '0;
        for (int p = 0; p < NWIN; p++) begin
            if (p >= first && p < last) begin
                for (int j = 0; j + 1 < NWIN; j++) begin
                    if ((j % 2) == (p % 2) && v[j] > v[j+1]) begin
                        t      = v[j];
                        v[j]   = v[j+1];
                        v[j+1] = t;
                    end
                end
            end
        end
        return v;
    endfunction

endpackage

// ===== rtl/rmf_ram.sv =====
`timescale 1ns / 1ps

module rmf_ram #(
    parameter int WIDTH = 48,
    parameter int DEPTH = 2048
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== rtl/rmf_line_window.sv =====
`timescale 1ns / 1ps

module rmf_line_window (
    input  logic              aclk,
    input  logic              aresetn,
    input  rmf_pkg::dims_t    dims,
    input  logic              s_valid,
    output logic              s_ready,
    input  rmf_pkg::pix_in_t  s_data,
    output rmf_pkg::win_t     win,
    output rmf_pkg::win_ctl_t win_ctl,
    input  logic              win_ready
);

    logic [rmf_pkg::COL_W-1:0]  col_count_reg, col_count_next;
    logic [rmf_pkg::ROW_W-1:0]  row_count_reg, row_count_next;
    logic [rmf_pkg::WEXT_W-1:0] w_raw, w_eff, col_inc;
    logic [rmf_pkg::ROW_W-1:0]  h_eff;
    logic [rmf_pkg::ROW_W:0]    row_inc;
    logic                       col_wrap, row_wrap, emit, last;

    logic                       s1_valid_reg;
    rmf_pkg::pix_in_t           s1_pix_reg;
    logic [rmf_pkg::COL_W-1:0]  s1_addr_reg;
    logic                       s1_emit_reg, s1_last_reg;
    logic                       fwd_hit_reg;
    rmf_pkg::line_vec_t         fwd_data_reg;

    logic [rmf_pkg::LINE_W-1:0] rd_data;
    rmf_pkg::line_vec_t         line_old, line_new;
    rmf_pkg::win_t              win_reg;
    logic                       win_valid_reg, win_last_reg;
    logic                       accept, adv1, free2;

    // effective frame size
    always_comb begin
        w_raw = rmf_pkg::WEXT_W'(dims.width);
        priority if (dims.width == '0) begin
            w_eff = rmf_pkg::WEXT_W'(1);
        end else if (w_raw > rmf_pkg::WEXT_W'(rmf_pkg::MAX_WIDTH)) begin
            w_eff = rmf_pkg::WEXT_W'(rmf_pkg::MAX_WIDTH);
        end else begin
            w_eff = w_raw;
        end
        h_eff = (dims.height == '0) ? rmf_pkg::ROW_W'(1) : dims.height;
    end

    assign col_inc  = rmf_pkg::WEXT_W'(col_count_reg) + rmf_pkg::WEXT_W'(1);
    assign row_inc  = {1'b0, row_count_reg} + {{rmf_pkg::ROW_W{1'b0}}, 1'b1};
    assign col_wrap = col_inc >= w_eff;
    assign row_wrap = row_inc >= {1'b0, h_eff};
    assign emit     = (row_count_reg >= rmf_pkg::ROW_W'(rmf_pkg::NLINES))
                   && (col_count_reg >= rmf_pkg::COL_W'(rmf_pkg::NLINES));
    assign last     = (row_inc == {1'b0, h_eff}) && (col_inc == w_eff);

    always_comb begin
        col_count_next = col_count_reg;
        row_count_next = row_count_reg;
        if (accept) begin
            if (col_wrap) begin
                col_count_next = '0;
                row_count_next = row_wrap ? '0 : row_inc[rmf_pkg::ROW_W-1:0];
            end else begin
                col_count_next = col_inc[rmf_pkg::COL_W-1:0];
            end
        end
    end

    // pipeline handshake
    assign free2   = !win_valid_reg || win_ready;
    assign adv1    = s1_valid_reg && free2;
    assign s_ready = !s1_valid_reg || adv1;
    assign accept  = s_valid && s_ready;

    // line store column: oldest row first, incoming pixel joins at the end
    always_comb begin
        line_old = fwd_hit_reg ? fwd_data_reg : rmf_pkg::line_vec_t'(rd_data);
        for (int i = 0; i < rmf_pkg::NLINES - 1; i++) begin
            line_new[i] = line_old[i+1];
        end
        line_new[rmf_pkg::NLINES-1] = s1_pix_reg;
    end

    rmf_ram #(
        .WIDTH (rmf_pkg::LINE_W),
        .DEPTH (rmf_pkg::MAX_WIDTH)
    ) u_line_ram (
        .aclk  (aclk),
        .we    (adv1),
        .waddr (s1_addr_reg),
        .wdata (rmf_pkg::LINE_W'(line_new)),
        .re    (accept),
        .raddr (col_count_reg),
        .rdata (rd_data)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            col_count_reg <= '0;
            row_count_reg <= '0;
            s1_valid_reg  <= 1'b0;
            fwd_hit_reg   <= 1'b0;
            win_valid_reg <= 1'b0;
        end else begin
            col_count_reg <= col_count_next;
            row_count_reg <= row_count_next;
            if (s_ready) begin
                s1_valid_reg <= s_valid;
            end
            if (accept) begin
                // write of the same column lands on the edge of this read
                fwd_hit_reg <= adv1 && (s1_addr_reg == col_count_reg);
            end
            if (adv1) begin
                win_valid_reg <= s1_emit_reg;
            end else if (win_ready) begin
                win_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            s1_pix_reg   <= s_data;
            s1_addr_reg  <= col_count_reg;
            s1_emit_reg  <= emit;
            s1_last_reg  <= last;
            fwd_data_reg <= line_new;
        end
        if (adv1) begin
            win_last_reg <= s1_last_reg;
            for (int i = 0; i < rmf_pkg::SPAN; i++) begin
                for (int j = 0; j < rmf_pkg::SPAN - 1; j++) begin
                    win_reg[i][j] <= win_reg[i][j+1];
                end
            end
            for (int i = 0; i < rmf_pkg::NLINES; i++) begin
                win_reg[i][rmf_pkg::SPAN-1] <= line_old[i];
            end
            win_reg[rmf_pkg::SPAN-1][rmf_pkg::SPAN-1] <= s1_pix_reg;
        end
    end

    assign win           = win_reg;
    assign win_ctl.valid = win_valid_reg;
    assign win_ctl.last  = win_last_reg;

endmodule

// ===== rtl/rmf_median.sv =====
`timescale 1ns / 1ps

module rmf_median (
    input  logic              aclk,
    input  logic              aresetn,
    input  rmf_pkg::win_t     win,
    input  rmf_pkg::win_ctl_t win_ctl,
    output logic              win_ready,
    output logic              m_valid,
    input  logic              m_ready,
    output rmf_pkg::pix_out_t m_data
);

    rmf_pkg::chan_arr_t red_a, green_a, blue_a;
    rmf_pkg::chan_arr_t red_s, green_s, blue_s;
    rmf_pkg::chan_arr_t sa_red_reg, sa_green_reg, sa_blue_reg;
    logic               sa_valid_reg, sa_last_reg;
    logic               out_free, adv_a, free_a;
    logic               m_valid_reg;
    rmf_pkg::pix_out_t  m_data_reg, m_data_next;

    always_comb begin
        for (int i = 0; i < rmf_pkg::SPAN; i++) begin
            for (int j = 0; j < rmf_pkg::SPAN; j++) begin
                red_a[i*rmf_pkg::SPAN+j]   = win[i][j].red_in;
                green_a[i*rmf_pkg::SPAN+j] = win[i][j].green_in;
                blue_a[i*rmf_pkg::SPAN+j]  = win[i][j].blue_in;
            end
        end
    end

    // first half of the sorting passes
    assign red_s   = rmf_pkg::oets(red_a, 0, rmf_pkg::HALF);
    assign green_s = rmf_pkg::oets(green_a, 0, rmf_pkg::HALF);
    assign blue_s  = rmf_pkg::oets(blue_a, 0, rmf_pkg::HALF);

    assign out_free  = !m_valid_reg || m_ready;
    assign adv_a     = sa_valid_reg && out_free;
    assign free_a    = !sa_valid_reg || adv_a;
    assign win_ready = free_a;

    // remaining passes, middle element taken
    always_comb begin
        rmf_pkg::chan_arr_t r, g, b;
        r = rmf_pkg::oets(sa_red_reg, rmf_pkg::HALF, rmf_pkg::NWIN);
        g = rmf_pkg::oets(sa_green_reg, rmf_pkg::HALF, rmf_pkg::NWIN);
        b = rmf_pkg::oets(sa_blue_reg, rmf_pkg::HALF, rmf_pkg::NWIN);
        m_data_next.red_med    = r[rmf_pkg::HALF];
        m_data_next.green_med  = g[rmf_pkg::HALF];
        m_data_next.blue_med   = b[rmf_pkg::HALF];
        m_data_next.frame_last = sa_last_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sa_valid_reg <= 1'b0;
            m_valid_reg  <= 1'b0;
        end else begin
            if (free_a) begin
                sa_valid_reg <= win_ctl.valid;
            end
            if (out_free) begin
                m_valid_reg <= sa_valid_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (win_ctl.valid && free_a) begin
            sa_red_reg   <= red_s;
            sa_green_reg <= green_s;
            sa_blue_reg  <= blue_s;
            sa_last_reg  <= win_ctl.last;
        end
        if (adv_a) begin
            m_data_reg <= m_data_next;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

endmodule

// ===== rtl/rgb_median_filter_core.sv =====
`timescale 1ns / 1ps
// channel   ports                                   direction
// pixel in  s_valid s_ready s_data                  in
// median    m_valid m_ready m_data                  out
// config    cfg_valid cfg_ready cfg_index cfg_data  in
//
// one pixel per cycle sustained while m_ready is high; an accepted pixel reaches the output register
// after the line ram read, window shift and two halves of the sorting network
// synchronous active-low reset clears counters and pipeline valids; line ram is not cleared
// m_ready low fills the pipeline back to s_ready; config writes are always accepted (cfg_ready is tied high)

module rgb_median_filter_core (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_valid,
    output logic                            s_ready,
    input  rmf_pkg::pix_in_t                s_data,
    output logic                            m_valid,
    input  logic                            m_ready,
    output rmf_pkg::pix_out_t               m_data,
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [rmf_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [rmf_pkg::CFG_W-1:0]       cfg_data
);

    rmf_pkg::dims_t    dims_reg;
    rmf_pkg::win_t     win;
    rmf_pkg::win_ctl_t win_ctl;
    logic              win_ready;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            dims_reg.width  <= rmf_pkg::IMAGE_WIDTH_RST;
            dims_reg.height <= rmf_pkg::IMAGE_HEIGHT_RST;
        end else if (cfg_valid) begin
            unique case (cfg_index)
                rmf_pkg::REG_IMAGE_WIDTH: begin
                    dims_reg.width <= cfg_data;
                end
                rmf_pkg::REG_IMAGE_HEIGHT: begin
                    dims_reg.height <= cfg_data;
                end
                default: begin
                end
            endcase
        end
    end

    rmf_line_window u_line_window (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .dims      (dims_reg),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .win       (win),
        .win_ctl   (win_ctl),
        .win_ready (win_ready)
    );

    rmf_median u_median (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .win       (win),
        .win_ctl   (win_ctl),
        .win_ready (win_ready),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data)
    );

endmodule
